/* rtl/line_substring_matcher_assert.svh */
// Assertion macros for the substring matcher checker.
`ifndef LINE_SUBSTRING_MATCHER_ASSERT_SVH
`define LINE_SUBSTRING_MATCHER_ASSERT_SVH

// Same-cycle implication.
`define LSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_substring_matcher: assertion failed");

// Next-cycle implication.
`define LSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_substring_matcher: assertion failed");

`endif

/* rtl/lsm_pkg.sv */
package lsm_pkg;

    localparam int PATTERN_MAX_DEFAULT = 16;
    localparam int CFG_PATTERN_BYTES   = 16;
    localparam int IDX_W               = 7;   // positions up to the largest window
    localparam int LINE_LEN_W          = 16;
    localparam int LINE_NUM_W          = 32;

    localparam logic [2:0] CFG_PATTERN_LOW     = 3'd0;
    localparam logic [2:0] CFG_PATTERN_HIGH    = 3'd1;
    localparam logic [2:0] CFG_PATTERN_LENGTH  = 3'd2;
    localparam logic [2:0] CFG_IGNORE_CASE     = 3'd3;
    localparam logic [2:0] CFG_MAX_LINE_LENGTH = 3'd4;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG   = 2'd1;
    localparam logic [1:0] ERR_NO_NEWLINE = 2'd2;

    localparam logic [7:0]            NEWLINE         = 8'h0A;
    localparam logic [7:0]            UPPER_A         = 8'h41;
    localparam logic [7:0]            UPPER_Z         = 8'h5A;
    localparam logic [7:0]            CASE_OFFSET     = 8'h20;
    localparam logic [LINE_LEN_W-1:0] MAX_LINE_RESET  = 16'd4095;

    typedef struct packed {
        logic [CFG_PATTERN_BYTES-1:0][7:0] pattern;
        logic [4:0]                        pattern_length;
        logic                              ignore_case;
        logic [LINE_LEN_W-1:0]             max_line_length;
    } lsm_cfg_t;

    function automatic logic [7:0] fold(input logic [7:0] b, input logic ic);
        if (ic && b >= UPPER_A && b <= UPPER_Z)
            return b + CASE_OFFSET;
        return b;
    endfunction

    function automatic logic [7:0] pattern_at(input lsm_cfg_t c, input logic [IDX_W-1:0] idx);
        if (idx < IDX_W'(CFG_PATTERN_BYTES))
            return c.pattern[idx[3:0]];
        return 8'd0;
    endfunction

endpackage

/* rtl/lsm_cell.sv */
module lsm_cell
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic [7:0] byte_in,
    input  logic [7:0] pattern_byte,
    input  logic       in_use,
    input  logic       ignore_case,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // compare against the byte this cell takes on the shift
    assign hit = !in_use
        || (lsm_pkg::fold(byte_in, ignore_case) == lsm_pkg::fold(pattern_byte, ignore_case));

    assign byte_next = shift_en ? byte_in : byte_reg;
    assign byte_out  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

/* rtl/lsm_cfg.sv */
module lsm_cfg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data,
    output lsm_pkg::lsm_cfg_t cfg
);

    lsm_pkg::lsm_cfg_t cfg_reg;
    lsm_pkg::lsm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lsm_pkg::CFG_PATTERN_LOW:     cfg_next.pattern[7:0]     = cfg_data;
                lsm_pkg::CFG_PATTERN_HIGH:    cfg_next.pattern[15:8]    = cfg_data;
                lsm_pkg::CFG_PATTERN_LENGTH:  cfg_next.pattern_length   = cfg_data[4:0];
                lsm_pkg::CFG_IGNORE_CASE:     cfg_next.ignore_case      = cfg_data[0];
                lsm_pkg::CFG_MAX_LINE_LENGTH: cfg_next.max_line_length  = cfg_data[15:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern         <= '0;
            cfg_reg.pattern_length  <= '0;
            cfg_reg.ignore_case     <= 1'b0;
            cfg_reg.max_line_length <= lsm_pkg::MAX_LINE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/line_substring_matcher.sv */
// Line substring matcher.
// Input channel (in_valid/in_ready): one text byte per beat, with end_of_input
// marking the last byte of a file. Output channel (out_valid/out_ready): one
// beat per finished line, carrying line_matched, line_number (from 1 within
// the file, saturating) and line_error. Config channel (cfg_valid/cfg_ready):
// always ready, register index and 64-bit data; write only while idle.
// Throughput is one byte per cycle while in_ready is high: the window is a row
// of PATTERN_MAX byte cells that shift on each accepted byte (not on dropped or
// too-long bytes) and compare in parallel. The result of a newline byte (or
// error) is registered and on the output in the cycle after the byte is accepted.
// A single output register holds the pending result; in_ready is low only
// while that register is full and out_ready is low, so a stalled receiver
// holds the input back after at most one result.
// After a too-long line or a missing final newline the error result is sent
// and every later byte is accepted and dropped until reset.
// Reset clears the window, counters and error state and loads the default
// configuration (empty pattern, case sensitive, 4095-byte lines).
module line_substring_matcher
#(
    parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEFAULT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           end_of_input,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           line_matched,
    output logic [lsm_pkg::LINE_NUM_W-1:0] line_number,
    output logic [1:0]                     line_error,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [63:0]                    cfg_data
);

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int CW = (LW > 5) ? LW : 5;

    lsm_pkg::lsm_cfg_t cfg;

    logic [LW-1:0]                  len_c;
    logic [CW-1:0]                  len_wide;
    logic [PATTERN_MAX-1:0][7:0]    window;
    logic [PATTERN_MAX-1:0]         hits;

    logic [lsm_pkg::LINE_LEN_W-1:0] bytes_in_line_reg, bytes_in_line_next;
    logic                           match_seen_reg, match_seen_next;
    logic [lsm_pkg::LINE_NUM_W-1:0] line_counter_reg, line_counter_next;
    logic                           halted_reg, halted_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           matched_reg, matched_next;
    logic [lsm_pkg::LINE_NUM_W-1:0] number_reg, number_next;
    logic [1:0]                     error_reg, error_next;

    logic                           accept;
    logic                           active;
    logic                           too_long;
    logic                           shift_en;
    logic [lsm_pkg::LINE_LEN_W-1:0] bytes_inc;
    logic                           match_now;
    logic                           match_upd;
    logic [lsm_pkg::LINE_NUM_W-1:0] next_ln;

    lsm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign cfg_ready = 1'b1;

    assign len_wide = CW'(cfg.pattern_length);
    assign len_c    = (len_wide > CW'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(len_wide);

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            logic [7:0]    byte_in;
            logic [LW-1:0] pos;

            if (k == 0)
            begin : g_head
                assign byte_in = data_byte;
            end
            else
            begin : g_link
                assign byte_in = window[k-1];
            end

            // window position k lines up with pattern byte len-1-k
            assign pos = len_c - LW'(1) - LW'(k);

            lsm_cell u_cell
            (
                .clk          (clk),
                .rst_n        (rst_n),
                .shift_en     (shift_en),
                .byte_in      (byte_in),
                .pattern_byte (lsm_pkg::pattern_at(cfg, lsm_pkg::IDX_W'(pos))),
                .in_use       (LW'(k) < len_c),
                .ignore_case  (cfg.ignore_case),
                .byte_out     (window[k]),
                .hit          (hits[k])
            );
        end
    endgenerate

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign active    = accept && !halted_reg;
    assign too_long  = bytes_in_line_reg >= cfg.max_line_length;
    assign shift_en  = active && !too_long;
    assign bytes_inc = bytes_in_line_reg + 16'd1;
    assign match_now = (len_c == '0) || ((&hits) && (bytes_inc >= 16'(len_c)));
    assign match_upd = match_seen_reg || match_now;
    assign next_ln   = (line_counter_reg == '1) ? line_counter_reg
                                                : line_counter_reg + 32'd1;

    always_comb
    begin
        bytes_in_line_next = bytes_in_line_reg;
        match_seen_next    = match_seen_reg;
        line_counter_next  = line_counter_reg;
        halted_next        = halted_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        matched_next       = matched_reg;
        number_next        = number_reg;
        error_next         = error_reg;

        if (active)
        begin
            if (too_long)
            begin
                out_valid_next = 1'b1;
                matched_next   = 1'b0;
                number_next    = next_ln;
                error_next     = lsm_pkg::ERR_TOO_LONG;
                halted_next    = 1'b1;
            end
            else if (data_byte == lsm_pkg::NEWLINE)
            begin
                out_valid_next     = 1'b1;
                matched_next       = match_upd;
                number_next        = next_ln;
                error_next         = lsm_pkg::ERR_NONE;
                bytes_in_line_next = '0;
                match_seen_next    = 1'b0;
                line_counter_next  = end_of_input ? '0 : next_ln;
            end
            else if (end_of_input)
            begin
                out_valid_next = 1'b1;
                matched_next   = 1'b0;
                number_next    = next_ln;
                error_next     = lsm_pkg::ERR_NO_NEWLINE;
                halted_next    = 1'b1;
            end
            else
            begin
                bytes_in_line_next = bytes_inc;
                match_seen_next    = match_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_in_line_reg <= '0;
            match_seen_reg    <= 1'b0;
            line_counter_reg  <= '0;
            halted_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            bytes_in_line_reg <= bytes_in_line_next;
            match_seen_reg    <= match_seen_next;
            line_counter_reg  <= line_counter_next;
            halted_reg        <= halted_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        number_reg  <= number_next;
        error_reg   <= error_next;
    end

    assign out_valid    = out_valid_reg;
    assign line_matched = matched_reg;
    assign line_number  = number_reg;
    assign line_error   = error_reg;

endmodule

/* rtl/lsm_checker.sv */
`include "line_substring_matcher_assert.svh"

module lsm_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           line_matched,
    input logic [lsm_pkg::LINE_NUM_W-1:0] line_number,
    input logic [1:0]                     line_error
);

    // stalled result beat holds
    `LSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(line_number) && $stable(line_error) && $stable(line_matched))

    // empty output register never blocks input
    `LSM_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // completed lines are numbered from 1
    `LSM_ASSERT_IMPL(a_line_from_one, clk, rst_n, out_valid && line_error == lsm_pkg::ERR_NONE, line_number != '0)

    // error beats never report a match
    `LSM_ASSERT_IMPL(a_error_no_match, clk, rst_n, out_valid && line_error != lsm_pkg::ERR_NONE, !line_matched)

    // nothing follows a delivered error
    `LSM_ASSERT_NEXT(a_halt_after_error, clk, rst_n, out_valid && out_ready && line_error != lsm_pkg::ERR_NONE, !out_valid)

endmodule

bind line_substring_matcher lsm_checker u_lsm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_matched (line_matched),
    .line_number  (line_number),
    .line_error   (line_error)
);
